// ----- rtl/refcounted_bitmap_page_allocator_top_macros.svh -----
// Assertion macros used by the allocator engine.
`ifndef REFCOUNTED_BITMAP_PAGE_ALLOCATOR_TOP_MACROS_SVH
`define REFCOUNTED_BITMAP_PAGE_ALLOCATOR_TOP_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define PBA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Condition that must never hold outside reset.
`define PBA_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error(msg);
`endif

// ----- rtl/pba_pkg.sv -----
// Shared constants and types of the page allocator.
package pba_pkg;
  localparam int MAX_PAGES_DEF = 4096;
  localparam logic [7:0]  REF_MAX   = 8'hFF;
  localparam logic [12:0] COUNT_MAX = 13'h1FFF;
  localparam logic [12:0] CFG_RESET = 13'd4096;

  localparam logic [2:0] REQ_ALLOC   = 3'd0;
  localparam logic [2:0] REQ_FREE    = 3'd1;
  localparam logic [2:0] REQ_REF     = 3'd2;
  localparam logic [2:0] REQ_QUERY   = 3'd3;
  localparam logic [2:0] REQ_INIT_FR = 3'd4;
  localparam logic [2:0] REQ_INIT_RS = 3'd5;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;

  localparam logic CFG_MANAGED = 1'b0;
  localparam logic CFG_USABLE  = 1'b1;

  typedef struct packed {
    logic rd;
    logic wr;
  } mem_cmd_t;
endpackage

// ----- rtl/pba_if.sv -----
// Request and result channel interfaces.
interface pba_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [11:0] start_page;
  logic [12:0] num_pages;
  modport source (output valid, req_type, start_page, num_pages, input ready);
  modport sink (input valid, req_type, start_page, num_pages, output ready);
endinterface

interface pba_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [11:0] result_page;
  logic [7:0]  ref_value;
  logic [12:0] free_page_total;
  modport source (output valid, status, result_page, ref_value, free_page_total,
                  input ready);
  modport sink (input valid, status, result_page, ref_value, free_page_total,
                output ready);
endinterface

// ----- rtl/refcounted_bitmap_page_allocator_top.sv -----
// After a word is accepted: an ignored word goes straight to its result; free, ref, query
// and reserve read each page and write it back where needed; init-free writes each page
// without a read. Single alloc scans from the hint and wraps once to page zero; run alloc
// scans from page zero, then writes each granted page. One word in flight: in_ready rises
// with out_valid, and a finished word waits while a previous result is not yet taken.
// Reset: a clearing pass marks every page used with count zero.
module refcounted_bitmap_page_allocator_top #(
  parameter int MAX_PAGES = pba_pkg::MAX_PAGES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  pba_req_if.sink     in_chan,
  pba_rsp_if.source   out_chan,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data
);
  import pba_pkg::*;
  localparam int AW = $clog2(MAX_PAGES);

  logic [12:0] managed_r, usable_r;
  mem_cmd_t    mem_cmd;
  logic [AW-1:0] mem_addr;
  logic [8:0]  mem_wdata, mem_rdata;

  // Hold the two configuration registers; the user must write them only while idle, the block does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      managed_r <= CFG_RESET;
      usable_r  <= CFG_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_MANAGED) managed_r <= cfg_data;
      else usable_r <= cfg_data;
    end
  end

  // Sequence each request over the page memory.
  pba_engine #(.MAX_PAGES(MAX_PAGES), .AW(AW)) u_engine (
    .clk, .rst_n,
    .managed(managed_r), .usable(usable_r),
    .in_valid(in_chan.valid), .in_ready(in_chan.ready),
    .in_type(in_chan.req_type), .in_index(in_chan.start_page),
    .in_count(in_chan.num_pages),
    .out_valid(out_chan.valid), .out_ready(out_chan.ready),
    .out_status(out_chan.status), .out_page(out_chan.result_page),
    .out_ref(out_chan.ref_value), .out_free(out_chan.free_page_total),
    .mem_cmd, .mem_addr, .mem_wdata, .mem_rdata
  );

  // Hold used bit and refcount of every page.
  pba_page_mem #(.DEPTH(MAX_PAGES), .AW(AW)) u_mem (
    .clk, .cmd(mem_cmd), .addr(mem_addr), .wdata(mem_wdata), .rdata(mem_rdata)
  );
endmodule

// ----- rtl/pba_page_mem.sv -----
// Per-page state memory: used bit and reference count, registered read.
module pba_page_mem #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic                clk,
  input  pba_pkg::mem_cmd_t   cmd,
  input  logic [AW-1:0]       addr,
  input  logic [8:0]          wdata,
  output logic [8:0]          rdata
);
  import pba_pkg::*;
  logic [8:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (cmd.wr) mem[addr] <= wdata;
    if (cmd.rd) rdata <= mem[addr];
  end
endmodule

// ----- rtl/pba_engine.sv -----
// Request sequencer: reads, modifies and writes back page state.
`include "refcounted_bitmap_page_allocator_top_macros.svh"
module pba_engine #(
  parameter int MAX_PAGES = pba_pkg::MAX_PAGES_DEF,
  parameter int AW = $clog2(MAX_PAGES)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [12:0]       managed,
  input  logic [12:0]       usable,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        in_type,
  input  logic [11:0]       in_index,
  input  logic [12:0]       in_count,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  output logic [11:0]       out_page,
  output logic [7:0]        out_ref,
  output logic [12:0]       out_free,
  output pba_pkg::mem_cmd_t mem_cmd,
  output logic [AW-1:0]     mem_addr,
  output logic [8:0]        mem_wdata,
  input  logic [8:0]        mem_rdata
);
  import pba_pkg::*;
  localparam int CW = (AW + 1 > 13) ? AW + 1 : 13;
  localparam logic [CW-1:0] PAGES = CW'(MAX_PAGES);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_EV   = 3'd3;
  localparam logic [2:0] S_FILL = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]    st_r, st_nxt;
  logic [CW-1:0] ptr_r, ptr_nxt, end_r, end_nxt, lim_r, lim_nxt, hint_r, hint_nxt;
  logic          wrap_r, wrap_nxt;
  logic [2:0]    typ_r, typ_nxt;
  logic [11:0]   idx_r, idx_nxt;
  logic [12:0]   cnt_r, cnt_nxt, run_r, run_nxt, used_r, used_nxt;
  logic [1:0]    stat_r, stat_nxt;
  logic [11:0]   rpage_r, rpage_nxt;
  logic [7:0]    rval_r, rval_nxt;
  logic          ov_r, ov_nxt;
  logic [1:0]    os_r, os_nxt;
  logic [11:0]   op_r, op_nxt;
  logic [7:0]    orf_r, orf_nxt;
  logic [12:0]   ofr_r, ofr_nxt;

  logic [CW-1:0] lim_in, whint, idx_w;
  logic [CW:0]   end_sum;
  logic          u;
  logic [7:0]    r, rn, rv;
  logic [12:0]   runn;

  function automatic logic [12:0] sat_add(input logic [12:0] a, input logic [12:0] b);
    logic [13:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, COUNT_MAX}) ? COUNT_MAX : s[12:0];
  endfunction

  assign lim_in  = (CW'(managed) > PAGES) ? PAGES : CW'(managed);
  assign idx_w   = CW'(in_index);
  assign end_sum = (CW+1)'(in_index) + (CW+1)'(in_count);
  assign whint   = (hint_r < lim_r) ? hint_r : lim_r;
  assign u       = mem_rdata[8];
  assign r       = mem_rdata[7:0];
  assign rn      = (r != 8'd0) ? r - 8'd1 : 8'd0;
  assign runn    = u ? 13'd0 : run_r + 13'd1;
  assign rv      = u ? rn : r;
  assign in_ready = (st_r == S_IDLE);
  assign out_valid  = ov_r;
  assign out_status = os_r;
  assign out_page   = op_r;
  assign out_ref    = orf_r;
  assign out_free   = ofr_r;

  always_comb begin
    st_nxt = st_r; ptr_nxt = ptr_r; end_nxt = end_r; lim_nxt = lim_r;
    hint_nxt = hint_r; wrap_nxt = wrap_r; typ_nxt = typ_r; idx_nxt = idx_r;
    cnt_nxt = cnt_r; run_nxt = run_r; used_nxt = used_r; stat_nxt = stat_r;
    rpage_nxt = rpage_r; rval_nxt = rval_r;
    ov_nxt = ov_r; os_nxt = os_r; op_nxt = op_r; orf_nxt = orf_r; ofr_nxt = ofr_r;
    mem_cmd = '0; mem_addr = ptr_r[AW-1:0]; mem_wdata = 9'd0;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    unique case (st_r)
      S_CLR: begin
        mem_cmd.wr = 1'b1;
        mem_wdata = {1'b1, 8'd0};
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r == PAGES - 1'b1) st_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          typ_nxt = in_type; idx_nxt = in_index; cnt_nxt = in_count;
          lim_nxt = lim_in; ptr_nxt = idx_w; wrap_nxt = 1'b0; run_nxt = 13'd0;
          end_nxt = (end_sum > (CW+1)'(lim_in)) ? lim_in : end_sum[CW-1:0];
          rpage_nxt = in_index; rval_nxt = 8'd0;
          stat_nxt = ST_IGNORED; st_nxt = S_FIN;
          case (in_type)
            REQ_ALLOC: begin
              rpage_nxt = 12'd0;
              if (in_count != 13'd0) begin
                stat_nxt = ST_NOFIT; st_nxt = S_RD;
                ptr_nxt = (in_count == 13'd1) ? hint_r : '0;
              end
            end
            REQ_FREE, REQ_INIT_FR, REQ_INIT_RS: begin
              if (in_count != 13'd0 && idx_w < lim_in &&
                  (in_index != 12'd0 || in_type != REQ_FREE)) begin
                stat_nxt = ST_DONE; st_nxt = S_RD;
              end
            end
            REQ_REF, REQ_QUERY: begin
              end_nxt = idx_w + 1'b1;
              if (in_index != 12'd0 && idx_w < lim_in) begin
                stat_nxt = ST_DONE; st_nxt = S_RD;
              end
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        if (typ_r == REQ_ALLOC && cnt_r == 13'd1) begin
          if (!wrap_r && ptr_r >= lim_r) begin
            wrap_nxt = 1'b1; ptr_nxt = '0;
          end else if (wrap_r && ptr_r >= whint) begin
            st_nxt = S_FIN;
          end else begin
            mem_cmd.rd = 1'b1; st_nxt = S_EV;
          end
        end else if (typ_r == REQ_ALLOC) begin
          if (ptr_r >= lim_r) st_nxt = S_FIN;
          else begin
            mem_cmd.rd = 1'b1; st_nxt = S_EV;
          end
        end else if (ptr_r >= end_r) begin
          st_nxt = S_FIN;
        end else if (typ_r == REQ_INIT_FR) begin
          mem_cmd.wr = 1'b1; ptr_nxt = ptr_r + 1'b1;
        end else begin
          mem_cmd.rd = 1'b1; st_nxt = S_EV;
        end
      end
      S_EV: begin
        st_nxt = S_RD;
        ptr_nxt = ptr_r + 1'b1;
        case (typ_r)
          REQ_ALLOC: begin
            if (cnt_r == 13'd1) begin
              if (!u) begin
                mem_cmd.wr = 1'b1; mem_wdata = {1'b1, 8'd1};
                used_nxt = sat_add(used_r, 13'd1);
                hint_nxt = ptr_r + 1'b1;
                stat_nxt = ST_DONE; rpage_nxt = ptr_r[11:0]; rval_nxt = 8'd1;
                st_nxt = S_FIN;
              end
            end else if (runn == cnt_r) begin
              ptr_nxt = ptr_r + 1'b1 - CW'(cnt_r);
              end_nxt = ptr_r + 1'b1;
              rpage_nxt = 12'(ptr_r + 1'b1 - CW'(cnt_r));
              stat_nxt = ST_DONE; rval_nxt = 8'd1;
              used_nxt = sat_add(used_r, cnt_r);
              st_nxt = S_FILL;
            end else begin
              run_nxt = runn;
            end
          end
          REQ_FREE: begin
            if (u) begin
              mem_cmd.wr = 1'b1;
              mem_wdata = (rn == 8'd0) ? 9'd0 : {1'b1, rn};
              if (rn == 8'd0 && used_r != 13'd0) used_nxt = used_r - 13'd1;
            end
            if (ptr_r == CW'(idx_r)) begin
              rval_nxt = rv;
              if (CW'(idx_r) < hint_r &&
                  (cnt_r != 13'd1 || (u && rn == 8'd0))) hint_nxt = CW'(idx_r);
            end
          end
          REQ_REF: begin
            rval_nxt = r;
            if (u && r != REF_MAX) begin
              mem_cmd.wr = 1'b1; mem_wdata = {1'b1, r + 8'd1}; rval_nxt = r + 8'd1;
            end
          end
          REQ_INIT_RS: begin
            mem_cmd.wr = 1'b1; mem_wdata = {1'b1, r};
            used_nxt = sat_add(used_r, 13'd1);
            if (ptr_r == CW'(idx_r)) rval_nxt = r;
          end
          default: rval_nxt = r;
        endcase
      end
      S_FILL: begin
        if (ptr_r >= end_r) st_nxt = S_FIN;
        else begin
          mem_cmd.wr = 1'b1; mem_wdata = {1'b1, 8'd1}; ptr_nxt = ptr_r + 1'b1;
        end
      end
      S_FIN: begin
        if (!ov_r || out_ready) begin
          ov_nxt = 1'b1; os_nxt = stat_r; op_nxt = rpage_r; orf_nxt = rval_r;
          ofr_nxt = (usable > used_r) ? usable - used_r : 13'd0;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR; ptr_r <= '0; hint_r <= '0; used_r <= 13'd0; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; ptr_r <= ptr_nxt; hint_r <= hint_nxt; used_r <= used_nxt;
      ov_r <= ov_nxt;
    end
    end_r <= end_nxt; lim_r <= lim_nxt; wrap_r <= wrap_nxt; typ_r <= typ_nxt;
    idx_r <= idx_nxt; cnt_r <= cnt_nxt; run_r <= run_nxt; stat_r <= stat_nxt;
    rpage_r <= rpage_nxt; rval_r <= rval_nxt;
    os_r <= os_nxt; op_r <= op_nxt; orf_r <= orf_nxt; ofr_r <= ofr_nxt;
  end

  `PBA_ASSERT_NEVER(a_no_rw_same_cycle, mem_cmd.rd && mem_cmd.wr, "read and write together")
  `PBA_ASSERT_IMP(a_ready_idle, in_ready, st_r == S_IDLE && !mem_cmd.wr, "ready while busy")
  `PBA_ASSERT_IMP(a_out_from_fin, $rose(out_valid), $past(st_r == S_FIN), "stray result")
endmodule

// ----- tb/pba_result_checker.sv -----
// Predictor and scoreboard for the page allocator's request and result channels.
module pba_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  pba_req_if          req,
  pba_rsp_if          rsp,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data,
  output int          fail_count,
  output int          pending,
  output int          checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import pba_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] page;
    logic [7:0]  refv;
    logic [12:0] free_total;
  } grant_t;

  grant_t      grant_q[$];
  bit          page_used[MAX_PAGES_DEF];
  logic [7:0]  page_refs[MAX_PAGES_DEF];
  int unsigned busy_total;
  int unsigned hint;
  int unsigned managed;
  int unsigned usable;

  function automatic void add_used(int unsigned n);
    int unsigned s;
    s = busy_total + n;
    busy_total = (s > COUNT_MAX) ? COUNT_MAX : s;
  endfunction

  // Decrement one page and release it at zero; tell whether it was released.
  function automatic bit release_page(int unsigned p);
    if (!page_used[p]) return 0;
    if (page_refs[p] > 0) page_refs[p]--;
    if (page_refs[p] == 0) begin
      page_used[p] = 0;
      if (busy_total > 0) busy_total--;
      return 1;
    end
    return 0;
  endfunction

  function automatic grant_t predict_grant(logic [2:0] kind, logic [11:0] idx,
                                           logic [12:0] cnt);
    grant_t      g;
    int unsigned lim, stop, wrap, i, run, first;
    bit          found;
    lim = (managed > MAX_PAGES_DEF) ? MAX_PAGES_DEF : managed;
    stop = idx + cnt;
    if (stop > lim) stop = lim;
    g.status = ST_IGNORED;
    g.page = idx;
    g.refv = '0;
    case (kind)
      REQ_ALLOC: begin
        g.page = '0;
        if (cnt == 1) begin
          wrap = (hint < lim) ? hint : lim;
          found = 0;
          g.status = ST_NOFIT;
          for (i = hint; i < lim && !found; i++)
            if (!page_used[i]) begin found = 1; first = i; end
          for (i = 0; i < wrap && !found; i++)
            if (!page_used[i]) begin found = 1; first = i; end
          if (found) begin
            page_used[first] = 1;
            page_refs[first] = 8'd1;
            add_used(1);
            hint = first + 1;
            g.status = ST_DONE;
            g.page = 12'(first);
            g.refv = 8'd1;
          end
        end else if (cnt > 1) begin
          run = 0;
          g.status = ST_NOFIT;
          for (i = 0; i < lim; i++) begin
            run = page_used[i] ? 0 : run + 1;
            if (run == cnt) begin
              first = i + 1 - cnt;
              for (int unsigned j = first; j <= i; j++) begin
                page_used[j] = 1;
                page_refs[j] = 8'd1;
              end
              add_used(cnt);
              g.status = ST_DONE;
              g.page = 12'(first);
              g.refv = 8'd1;
              break;
            end
          end
        end
      end
      REQ_FREE: begin
        if (idx != 0 && cnt != 0 && idx < lim) begin
          if (cnt == 1) begin
            if (release_page(idx) && idx < hint) hint = idx;
          end else begin
            for (i = idx; i < stop; i++) void'(release_page(i));
            if (idx < hint) hint = idx;
          end
          g.status = ST_DONE;
          g.refv = page_refs[idx];
        end
      end
      REQ_REF, REQ_QUERY: begin
        if (idx != 0 && idx < lim) begin
          if (kind == REQ_REF && page_used[idx] && page_refs[idx] < REF_MAX)
            page_refs[idx]++;
          g.status = ST_DONE;
          g.refv = page_refs[idx];
        end
      end
      REQ_INIT_FR, REQ_INIT_RS: begin
        if (cnt != 0 && idx < lim) begin
          for (i = idx; i < stop; i++) begin
            if (kind == REQ_INIT_FR) begin
              page_used[i] = 0;
              page_refs[i] = '0;
            end else begin
              page_used[i] = 1;
              add_used(1);
            end
          end
          g.status = ST_DONE;
          g.refv = page_refs[idx];
        end
      end
      default: ;
    endcase
    g.free_total = (usable > busy_total) ? 13'(usable - busy_total) : 13'd0;
    return g;
  endfunction

  always @(posedge clk) begin
    grant_t want;
    if (!rst_n) begin
      foreach (page_used[p]) begin
        page_used[p] = 1;
        page_refs[p] = '0;
      end
      busy_total = 0;
      hint = 0;
      managed = CFG_RESET;
      usable = CFG_RESET;
      grant_q.delete();
      fail_count = 0;
      checked = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_MANAGED) managed = cfg_data;
        else usable = cfg_data;
      end
      if (rsp.valid && rsp.ready) begin
        if (grant_q.size() == 0) begin
          $error("result word with nothing expected");
          fail_count++;
        end else begin
          want = grant_q.pop_front();
          checked++;
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp.status);
            fail_count++;
          end
          if (rsp.result_page !== want.page) begin
            $error("result_page: expected %0d, got %0d", want.page, rsp.result_page);
            fail_count++;
          end
          if (rsp.ref_value !== want.refv) begin
            $error("ref_value: expected %0d, got %0d", want.refv, rsp.ref_value);
            fail_count++;
          end
          if (rsp.free_page_total !== want.free_total) begin
            $error("free_page_total: expected %0d, got %0d", want.free_total,
                   rsp.free_page_total);
            fail_count++;
          end
        end
      end
      if (req.valid && req.ready)
        grant_q.push_back(predict_grant(req.req_type, req.start_page, req.num_pages));
    end
    pending = grant_q.size();
  end
endmodule

// ----- tb/refcounted_bitmap_page_allocator_top_tb.sv -----
// Stimulus, handshake pacing and verdict for the page allocator.
module refcounted_bitmap_page_allocator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pba_pkg::*;

  // Request types the block must ignore.
  localparam logic [2:0] REQ_UNKNOWN_LO = 3'd6;
  localparam logic [2:0] REQ_UNKNOWN_HI = 3'd7;
  localparam int CYCLE_LIMIT = 10_000_000;
  localparam int HOLD_OFF_CYCLES = 1500;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [12:0] cfg_data = '0;

  int fail_count, pending, checked;
  int words_sent = 0;
  int settings_run = 1;
  int cycles = 0;
  bit no_idle = 0;
  bit hold_off_go = 0;

  pba_req_if in_chan ();
  pba_rsp_if out_chan ();

  refcounted_bitmap_page_allocator_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan.sink),
    .out_chan (out_chan.source),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  pba_result_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (in_chan),
    .rsp       (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fail_count(fail_count),
    .pending   (pending),
    .checked   (checked)
  );

  always #5 clk = ~clk;

  // Watchdog: end the run if the block hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    in_chan.valid = 1'b0;
    in_chan.req_type = REQ_QUERY;
    in_chan.start_page = '0;
    in_chan.num_pages = '0;
    out_chan.ready = 1'b0;
  end

  // Mostly short gaps, a few long ones, none while idling is switched off.
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    int stall_left;
    stall_left = 0;
    @(posedge clk);
    forever begin
      if (hold_off_go) begin
        hold_off_go = 0;
        out_chan.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else if (no_idle) begin
        out_chan.ready <= 1'b1;
        @(posedge clk);
      end else if (stall_left > 0) begin
        out_chan.ready <= 1'b0;
        stall_left--;
        @(posedge clk);
      end else begin
        out_chan.ready <= 1'b1;
        stall_left = pick_gap();
        @(posedge clk);
      end
    end
  end

  // Offer one word and hold it until taken; enter and leave on a rising edge.
  task automatic send_word(logic [2:0] kind, logic [11:0] idx, logic [12:0] cnt);
    int gap;
    in_chan.valid <= 1'b1;
    in_chan.req_type <= kind;
    in_chan.start_page <= idx;
    in_chan.num_pages <= cnt;
    @(negedge clk);
    while (!in_chan.ready) @(negedge clk);
    @(posedge clk);
    words_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drain every outstanding result before touching the registers.
  task automatic wait_idle();
    in_chan.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic which, logic [12:0] value);
    cfg_we <= 1'b1;
    cfg_index <= which;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_pages(logic [12:0] managed, logic [12:0] usable);
    wait_idle();
    write_reg(CFG_MANAGED, managed);
    write_reg(CFG_USABLE, usable);
    settings_run++;
  endtask

  // One random request word, mostly well formed within the managed pages.
  task automatic send_random(int lim);
    int r, k;
    logic [2:0]  kind;
    logic [11:0] idx;
    logic [12:0] cnt;
    r = $urandom_range(0, 99);
    if (r < 25) kind = REQ_ALLOC;
    else if (r < 47) kind = REQ_FREE;
    else if (r < 62) kind = REQ_REF;
    else if (r < 72) kind = REQ_QUERY;
    else if (r < 82) kind = REQ_INIT_FR;
    else if (r < 88) kind = REQ_INIT_RS;
    else kind = $urandom_range(0, 1) ? REQ_UNKNOWN_LO : REQ_UNKNOWN_HI;
    k = $urandom_range(0, 99);
    if (k < 85 && lim > 0) idx = 12'($urandom_range(0, lim - 1));
    else idx = 12'($urandom());
    k = $urandom_range(0, 99);
    if (k < 70) cnt = (kind == REQ_ALLOC && k < 45) ? 13'd1 : 13'($urandom_range(1, 4));
    else if (k < 88) cnt = 13'($urandom_range(0, 16));
    else cnt = 13'($urandom());
    send_word(kind, idx, cnt);
  endtask

  // Open a setting with a freed range, then mix random words.
  task automatic run_phase(logic [12:0] managed, logic [12:0] usable, int n_words);
    int lim;
    set_pages(managed, usable);
    lim = (managed > MAX_PAGES_DEF) ? MAX_PAGES_DEF : managed;
    send_word(REQ_INIT_FR, '0, managed);
    repeat (n_words) send_random(lim);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset map is all used, so the first alloc finds nothing.
    send_word(REQ_ALLOC, '0, 13'd1);
    send_word(REQ_ALLOC, '0, 13'd0);
    send_word(REQ_QUERY, '0, 13'd1);
    send_word(REQ_FREE, '0, 13'd1);
    send_word(REQ_REF, '0, 13'd1);
    send_word(REQ_UNKNOWN_LO, 12'hFFF, 13'h1FFF);
    send_word(REQ_UNKNOWN_HI, 12'h555, 13'h0AAA);
    send_word(REQ_INIT_FR, '0, 13'd0);
    send_word(REQ_INIT_FR, '0, 13'd4096);
    send_word(REQ_ALLOC, '0, 13'd1);
    send_word(REQ_ALLOC, '0, 13'd3);
    send_word(REQ_ALLOC, '0, 13'h1FFF);
    send_word(REQ_REF, 12'd1, 13'd0);
    send_word(REQ_QUERY, 12'd1, 13'd0);
    send_word(REQ_FREE, 12'd1, 13'd1);
    send_word(REQ_FREE, 12'd1, 13'd1);
    send_word(REQ_FREE, 12'd2, 13'd5);
    send_word(REQ_REF, 12'd2, 13'd1);
    send_word(REQ_INIT_RS, 12'd4090, 13'd100);
    send_word(REQ_QUERY, 12'hFFF, 13'd1);
    send_word(REQ_REF, 12'hFFF, 13'd1);
    send_word(REQ_FREE, 12'hFFF, 13'd1);
    send_word(REQ_INIT_FR, 12'd10, 13'h1FFF);
    send_word(REQ_ALLOC, '0, 13'd1);

    // Saturate one page's count, then lower it with repeated frees.
    set_pages(13'd16, 13'd16);
    send_word(REQ_INIT_FR, '0, 13'd16);
    send_word(REQ_ALLOC, '0, 13'd1);
    send_word(REQ_ALLOC, '0, 13'd1);
    repeat (260) send_word(REQ_REF, 12'd1, 13'd1);
    repeat (3) send_word(REQ_FREE, 12'd1, 13'd1);
    send_word(REQ_QUERY, 12'd1, 13'd1);

    // Long receiver hold-off while words keep coming, so the block backs up.
    set_pages(13'd64, 13'd64);
    hold_off_go = 1;
    send_word(REQ_INIT_FR, '0, 13'd64);
    repeat (200) send_random(64);
    run_phase(13'd128, 13'd100, 200);
    no_idle = 1;
    run_phase(13'd200, 13'h1FFF, 250);
    no_idle = 0;
    run_phase(13'd1, 13'd0, 60);
    run_phase(13'd0, 13'd4096, 30);
    run_phase(13'd37, 13'h1FFF, 250);
    run_phase(13'd96, 13'd0, 200);
    run_phase(13'd256, 13'd300, 200);
    run_phase(13'h1FFF, 13'd4096, 25);
    run_phase(13'd4096, 13'd4096, 20);

    wait_idle();
    repeat (50) @(posedge clk);
    $display("Covered %0d request words over %0d page settings; %0d results checked.",
             words_sent, settings_run, checked);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
